### sv/rail_fence_cipher_core_defines.svh
// Assertion macros for the rail fence cipher core.
// Used by the port checker; no other dependencies.
`ifndef RAIL_FENCE_CIPHER_CORE_DEFINES_SVH
`define RAIL_FENCE_CIPHER_CORE_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RFC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the core clock and reset.
`define RFC_ASSERT(lbl, prop, msg) \
    `RFC_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

### sv/rfc_pkg.sv
// Shared types and constants for the rail fence cipher core.
// No dependencies.
package rfc_pkg;

    localparam int RFC_MAX_LEN = 64;
    localparam int BYTE_W      = 8;
    localparam int RAIL_W      = 7;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_RAIL_COUNT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 8'd1;

    localparam logic [RAIL_W-1:0] RAIL_RESET = 7'd2;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCATTER,
        ST_DRAIN,
        ST_EMIT
    } rfc_state_t;

    typedef struct packed {
        logic start;
        logic advance;
    } rfc_gen_ctl_t;

endpackage

### sv/rfc_order_gen.sv
// Zigzag position generator: walks message positions rail by rail.
// Depends on rfc_pkg.
module rfc_order_gen #(
    parameter int MAX_LEN = rfc_pkg::RFC_MAX_LEN
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rfc_pkg::rfc_gen_ctl_t      ctl,
    input  logic [rfc_pkg::RAIL_W-1:0] rail_count,
    input  logic [$clog2(MAX_LEN):0]   msg_len,
    output logic [$clog2(MAX_LEN)-1:0] pos
);
    import rfc_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = AW + 1;
    localparam int PW = AW + 2;

    logic [LW-1:0] rail_reg, rail_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          phase_reg, phase_next;

    logic          identity;
    logic [LW-1:0] rails;
    logic [LW-1:0] last_rail;
    logic [PW-1:0] step;
    logic [PW-1:0] sum;

    always_comb begin
        identity  = (rail_count <= RAIL_W'(1)) || (rail_count >= RAIL_W'(msg_len));
        rails     = rail_count[LW-1:0];
        last_rail = rails - LW'(1);
        if ((rail_reg == '0) || (rail_reg == last_rail)) begin
            step = PW'(last_rail) << 1;
        end else if (phase_reg) begin
            step = PW'(rail_reg) << 1;
        end else begin
            step = PW'(last_rail - rail_reg) << 1;
        end
        sum = pos_reg + step;
    end

    always_comb begin
        rail_next  = rail_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        priority if (ctl.start) begin
            rail_next  = '0;
            pos_next   = '0;
            phase_next = 1'b0;
        end else if (ctl.advance) begin
            priority if (identity) begin
                pos_next = pos_reg + PW'(1);
            end else if (sum >= PW'(msg_len)) begin
                rail_next  = rail_reg + LW'(1);
                pos_next   = PW'(rail_reg + LW'(1));
                phase_next = 1'b0;
            end else begin
                pos_next   = sum;
                phase_next = ~phase_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rail_reg  <= '0;
            pos_reg   <= '0;
            phase_reg <= 1'b0;
        end else begin
            rail_reg  <= rail_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
        end
    end

    assign pos = pos_reg[AW-1:0];

endmodule

### sv/rfc_buffer.sv
// Message store and permutation scratch memories, registered reads.
// Depends on rfc_pkg.
module rfc_buffer #(
    parameter int MAX_LEN = rfc_pkg::RFC_MAX_LEN
) (
    input  logic                       aclk,
    input  logic                       msg_we,
    input  logic [$clog2(MAX_LEN)-1:0] msg_waddr,
    input  logic [rfc_pkg::BYTE_W-1:0] msg_wdata,
    input  logic                       msg_re,
    input  logic [$clog2(MAX_LEN)-1:0] msg_raddr,
    output logic [rfc_pkg::BYTE_W-1:0] msg_rdata,
    input  logic                       perm_we,
    input  logic [$clog2(MAX_LEN)-1:0] perm_waddr,
    input  logic [rfc_pkg::BYTE_W-1:0] perm_wdata,
    input  logic                       perm_re,
    input  logic [$clog2(MAX_LEN)-1:0] perm_raddr,
    output logic [rfc_pkg::BYTE_W-1:0] perm_rdata
);
    import rfc_pkg::*;

    logic [BYTE_W-1:0] msg_mem  [MAX_LEN];
    logic [BYTE_W-1:0] perm_mem [MAX_LEN];
    logic [BYTE_W-1:0] msg_rdata_reg;
    logic [BYTE_W-1:0] perm_rdata_reg;

    always_ff @(posedge aclk) begin
        if (msg_we) begin
            msg_mem[msg_waddr] <= msg_wdata;
        end
        if (msg_re) begin
            msg_rdata_reg <= msg_mem[msg_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (perm_we) begin
            perm_mem[perm_waddr] <= perm_wdata;
        end
        if (perm_re) begin
            perm_rdata_reg <= perm_mem[perm_raddr];
        end
    end

    assign msg_rdata  = msg_rdata_reg;
    assign perm_rdata = perm_rdata_reg;

endmodule

### sv/rail_fence_cipher_core.sv
// Rail fence cipher core. Load: one byte per cycle, s_tready high while collecting.
// After the tlast beat, encrypt moves straight to emission; decrypt first scatters the
// message into scratch memory and then emits.
// Emission: a byte is read only with no read outstanding and the output free or taken.
// Reset (aresetn low, synchronous): empty buffer, overflow clear, rail_count 2,
// encrypt mode; memory contents are not cleared.
module rail_fence_cipher_core #(
    parameter int MAX_LEN = rfc_pkg::RFC_MAX_LEN
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rfc_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,   // is_final
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rfc_pkg::BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
    output logic                           m_tlast,   // out_final
    output logic [0:0]                     m_tuser,   // [0] overflowed
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rfc_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = AW + 1;

    rfc_state_t state_reg, state_next;

    logic [RAIL_W-1:0] rail_reg;
    logic              decrypt_reg;
    logic [LW-1:0]     len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic [LW-1:0]     cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_data_reg;
    logic              m_last_reg;
    logic              m_ovf_reg;

    rfc_gen_ctl_t      gen_ctl;
    logic [AW-1:0]     gen_pos;

    logic              s_accept;
    logic              full;
    logic              issue;
    logic              msg_re;
    logic [AW-1:0]     msg_raddr;
    logic [BYTE_W-1:0] msg_rdata;
    logic              perm_re;
    logic [BYTE_W-1:0] perm_rdata;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_LOAD);
    assign s_accept  = s_tvalid && s_tready;
    assign full      = (len_reg == LW'(MAX_LEN));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rail_reg    <= RAIL_RESET;
            decrypt_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_RAIL_COUNT) begin
                rail_reg <= cfg_data[RAIL_W-1:0];
            end
            if (cfg_index == REG_DECRYPT_MODE) begin
                decrypt_reg <= cfg_data[0];
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        cnt_next       = cnt_reg;
        gen_ctl        = '0;
        issue          = 1'b0;
        msg_re         = 1'b0;
        msg_raddr      = gen_pos;
        perm_re        = 1'b0;
        wr_pend_next   = 1'b0;
        wr_addr_next   = gen_pos;
        pend_last_next = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (!full) begin
                        len_next = len_reg + LW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        cnt_next      = '0;
                        gen_ctl.start = 1'b1;
                        state_next    = decrypt_reg ? ST_SCATTER : ST_EMIT;
                    end
                end
            end
            ST_SCATTER: begin
                msg_re          = 1'b1;
                msg_raddr       = cnt_reg[AW-1:0];
                gen_ctl.advance = 1'b1;
                wr_pend_next    = 1'b1;
                cnt_next        = cnt_reg + LW'(1);
                if (cnt_reg == len_reg - LW'(1)) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                issue = !pend_reg && (!m_valid_reg || m_tready) && (cnt_reg != len_reg);
                if (issue) begin
                    if (decrypt_reg) begin
                        perm_re = 1'b1;
                    end else begin
                        msg_re          = 1'b1;
                        gen_ctl.advance = 1'b1;
                    end
                    cnt_next       = cnt_reg + LW'(1);
                    pend_last_next = (cnt_reg == len_reg - LW'(1));
                end
                if (!pend_reg && (cnt_reg == len_reg)) begin
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
        pend_next = issue;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            wr_pend_reg   <= wr_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg <= wr_addr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pend_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            m_data_reg <= decrypt_reg ? perm_rdata : msg_rdata;
            m_last_reg <= pend_last_reg;
            m_ovf_reg  <= ovf_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_ovf_reg;

    rfc_order_gen #(
        .MAX_LEN (MAX_LEN)
    ) u_order_gen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (gen_ctl),
        .rail_count (rail_reg),
        .msg_len    (len_reg),
        .pos        (gen_pos)
    );

    rfc_buffer #(
        .MAX_LEN (MAX_LEN)
    ) u_buffer (
        .aclk       (aclk),
        .msg_we     (s_accept && !full),
        .msg_waddr  (len_reg[AW-1:0]),
        .msg_wdata  (s_tdata),
        .msg_re     (msg_re),
        .msg_raddr  (msg_raddr),
        .msg_rdata  (msg_rdata),
        .perm_we    (wr_pend_reg),
        .perm_waddr (wr_addr_reg),
        .perm_wdata (msg_rdata),
        .perm_re    (perm_re),
        .perm_raddr (cnt_reg[AW-1:0]),
        .perm_rdata (perm_rdata)
    );

endmodule

### sv/rfc_port_checker.sv
// Port-level checks for the rail fence cipher core, bound to the top level.
// Depends on rfc_pkg and rail_fence_cipher_core_defines.svh.
`include "rail_fence_cipher_core_defines.svh"

module rfc_port_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rfc_pkg::BYTE_W-1:0]     m_tdata,
    input logic                           m_tlast
);
    import rfc_pkg::*;

    // hold a stalled output beat
    `RFC_ASSERT(a_m_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output beat dropped or changed while stalled")
    // stop taking input once the last beat of a message is in
    `RFC_ASSERT(a_busy_after_last, s_tvalid && s_tready && s_tlast |=> !s_tready, "input taken right after a message end")
    // reopen input only after the last output beat is shown or gone
    `RFC_ASSERT(a_reopen, $rose(s_tready) |-> !m_tvalid || m_tlast, "input reopened mid-message")
    // take no input while a message is still going out
    `RFC_ASSERT(a_no_overlap, m_tvalid && !m_tlast |-> !s_tready, "input ready during emission")

endmodule

bind rail_fence_cipher_core rfc_port_checker u_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
